// File: rtl/csp_pkg.sv
// Shared types and constants for the critical section cycle profiler.
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

    typedef enum logic [1:0] {
        REQ_ENTER = 2'd0,
        REQ_EXIT  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_READ  = 2'd3
    } req_code_t;

    typedef enum logic [0:0] {
        CFG_CORE_CLOCK_HZ   = 1'b0,
        CFG_COUNTER_PRESENT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        NS_LATEST = 2'd0,
        NS_LEAST  = 2'd1,
        NS_MOST   = 2'd2,
        NS_MEAN   = 2'd3
    } ns_slot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_MUL,
        ST_NS,
        ST_NS_WAIT,
        ST_OUT
    } prof_state_t;

    // One nanosecond scale: 10^9 fits in 30 bits.
    localparam logic [29:0] NS_SCALE = 30'd1000000000;

    typedef struct packed {
        req_code_t   req_type;
        logic [31:0] cycle_now;
    } csp_req_t;

    typedef struct packed {
        logic [31:0] samples_taken;
        logic [31:0] latest_cycles;
        logic [31:0] least_cycles;
        logic [31:0] most_cycles;
        logic [63:0] cycle_sum;
        logic [31:0] mean_cycles;
        logic [31:0] latest_ns;
        logic [31:0] least_ns;
        logic [31:0] most_ns;
        logic [31:0] mean_ns;
        logic        measure_ok;
    } csp_rsp_t;

    // Divider handshake status.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/critical_section_cycle_profiler_core.sv
// Critical section cycle profiler: nesting tracker, statistics and read sequencer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  cfg     | in        | cfg_we             | cfg_index, cfg_wdata
//  s       | in        | s_valid / s_ready  | s_data  (csp_req_t)
//  m       | out       | m_valid / m_ready  | m_data  (csp_rsp_t)
//
// Enter, exit and clear transactions complete in the cycle they are accepted.
// A read holds s_ready low while one shared 64/32 divider runs up to five times
// (mean, then four ns conversions), 64 steps each; fewer when there are no
// samples (no mean division) or the clock is 0 (no ns).
// The result sits in an output register; the next transaction is taken while
// it waits, a further read only parks in ST_OUT until m_ready frees it.
// aresetn is synchronous, active low, and clears statistics and configuration.
`timescale 1ns / 1ps
`default_nettype none

module critical_section_cycle_profiler_core
    import csp_pkg::*;
#(
    parameter int NEST_BITS  = 8,
    parameter int CYCLE_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    // requests
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire csp_req_t    s_data,
    // statistics
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      csp_rsp_t    m_data
);

    // ---------------- configuration ----------------
    logic [31:0] clk_hz_reg;
    logic        present_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg  <= '0;
            present_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CORE_CLOCK_HZ:   clk_hz_reg  <= cfg_wdata;
                CFG_COUNTER_PRESENT: present_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------- section state and statistics ----------------
    logic [NEST_BITS-1:0]  nest_reg, nest_next;
    logic                  open_reg, open_next;
    logic [CYCLE_BITS-1:0] stamp_reg, stamp_next;
    logic [31:0]           tally_reg, tally_next;
    logic [CYCLE_BITS-1:0] recent_reg, recent_next;
    logic [CYCLE_BITS-1:0] short_reg, short_next;
    logic [CYCLE_BITS-1:0] long_reg, long_next;
    logic [63:0]           sum_reg, sum_next;

    logic                  s_fire;
    logic [CYCLE_BITS-1:0] now_cyc;
    logic [CYCLE_BITS-1:0] len;
    logic [64:0]           sum_add;
    logic [NEST_BITS-1:0]  nest_dec;

    assign s_fire   = s_valid && s_ready;
    assign now_cyc  = s_data.cycle_now[CYCLE_BITS-1:0];
    assign len      = now_cyc - stamp_reg;          // wraps modulo 2^CYCLE_BITS
    assign sum_add  = {1'b0, sum_reg} + 65'(len);
    assign nest_dec = nest_reg - NEST_BITS'(1);

    always_comb begin
        nest_next   = nest_reg;
        open_next   = open_reg;
        stamp_next  = stamp_reg;
        tally_next  = tally_reg;
        recent_next = recent_reg;
        short_next  = short_reg;
        long_next   = long_reg;
        sum_next    = sum_reg;
        if (s_fire) begin
            case (s_data.req_type)
                REQ_ENTER: begin
                    if (present_reg) begin
                        if (nest_reg == '0) begin
                            stamp_next = now_cyc;
                            open_next  = 1'b1;
                        end
                        if (!(&nest_reg)) begin
                            nest_next = nest_reg + NEST_BITS'(1);
                        end
                    end
                end
                REQ_EXIT: begin
                    if (present_reg && nest_reg != '0) begin
                        nest_next = nest_dec;
                        // outermost exit closes the section
                        if (nest_dec == '0 && open_reg) begin
                            open_next   = 1'b0;
                            recent_next = len;
                            sum_next    = sum_add[64] ? '1 : sum_add[63:0];
                            if (tally_reg != '1) begin
                                tally_next = tally_reg + 32'd1;
                            end
                            if (tally_reg == '0) begin
                                short_next = len;
                                long_next  = len;
                            end else begin
                                if (len < short_reg) short_next = len;
                                if (len > long_reg)  long_next  = len;
                            end
                        end
                    end
                end
                REQ_CLEAR: begin
                    nest_next   = '0;
                    open_next   = 1'b0;
                    stamp_next  = '0;
                    tally_next  = '0;
                    recent_next = '0;
                    short_next  = '0;
                    long_next   = '0;
                    sum_next    = '0;
                end
                default: ;  // read: handled by the sequencer
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nest_reg   <= '0;
            open_reg   <= 1'b0;
            stamp_reg  <= '0;
            tally_reg  <= '0;
            recent_reg <= '0;
            short_reg  <= '0;
            long_reg   <= '0;
            sum_reg    <= '0;
        end else begin
            nest_reg   <= nest_next;
            open_reg   <= open_next;
            stamp_reg  <= stamp_next;
            tally_reg  <= tally_next;
            recent_reg <= recent_next;
            short_reg  <= short_next;
            long_reg   <= long_next;
            sum_reg    <= sum_next;
        end
    end

    // ---------------- read sequencer ----------------
    prof_state_t state_reg, state_next;
    ns_slot_t    slot_reg;
    logic [31:0] mean_reg;
    logic [61:0] prod_reg;
    logic [31:0] ns_reg [4];
    logic        m_valid_reg;
    csp_rsp_t    m_data_reg;

    // shared divider
    logic        div_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    div_stat_t   div_stat;
    logic [63:0] div_quo;
    logic [31:0] div_quo_sat;

    // sequencer strobes
    logic        mean_ld, mean_zero, prod_ld, ns_ld, ns_zero, out_ld, slot_clr;
    logic [31:0] mul_op;

    assign div_quo_sat = (div_quo[63:32] != '0) ? '1 : div_quo[31:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.req_type == REQ_READ) state_next = ST_MEAN;
            end
            ST_MEAN: begin
                state_next = (tally_reg == '0) ? ST_MUL : ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (div_stat.done) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = (clk_hz_reg == '0) ? ST_OUT : ST_NS;
            end
            ST_NS: begin
                state_next = ST_NS_WAIT;
            end
            ST_NS_WAIT: begin
                if (div_stat.done) state_next = (slot_reg == NS_MEAN) ? ST_OUT : ST_MUL;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        div_start    = 1'b0;
        div_dividend = 64'(prod_reg) + 64'(clk_hz_reg[31:1]);
        div_divisor  = clk_hz_reg;
        mean_ld      = 1'b0;
        mean_zero    = 1'b0;
        prod_ld      = 1'b0;
        ns_ld        = 1'b0;
        ns_zero      = 1'b0;
        out_ld       = 1'b0;
        slot_clr     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                slot_clr = 1'b1;
            end
            ST_MEAN: begin
                if (tally_reg == '0) begin
                    mean_zero = 1'b1;
                end else begin
                    div_start    = 1'b1;
                    div_dividend = sum_reg;
                    div_divisor  = tally_reg;
                end
            end
            ST_MEAN_WAIT: mean_ld = div_stat.done;
            ST_MUL: begin
                if (clk_hz_reg == '0) ns_zero = 1'b1;
                else                  prod_ld = 1'b1;
            end
            ST_NS:      div_start = 1'b1;
            ST_NS_WAIT: ns_ld     = div_stat.done;
            ST_OUT:     out_ld    = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_comb begin
        case (slot_reg)
            NS_LATEST: mul_op = 32'(recent_reg);
            NS_LEAST:  mul_op = 32'(short_reg);
            NS_MOST:   mul_op = 32'(long_reg);
            default:   mul_op = mean_reg;
        endcase
    end

    csp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= NS_LATEST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (slot_clr) begin
                slot_reg <= NS_LATEST;
            end else if (ns_ld) begin
                slot_reg <= ns_slot_t'(slot_reg + 2'd1);
            end
            if (out_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mean_zero) mean_reg <= '0;
        else if (mean_ld) mean_reg <= div_quo_sat;
        if (prod_ld) prod_reg <= 62'(mul_op) * 62'(NS_SCALE);
        if (ns_zero) begin
            for (int i = 0; i < 4; i++) ns_reg[i] <= '0;
        end else if (ns_ld) begin
            ns_reg[slot_reg] <= div_quo_sat;
        end
        if (out_ld) begin
            m_data_reg.samples_taken <= tally_reg;
            m_data_reg.latest_cycles <= 32'(recent_reg);
            m_data_reg.least_cycles  <= 32'(short_reg);
            m_data_reg.most_cycles   <= 32'(long_reg);
            m_data_reg.cycle_sum     <= sum_reg;
            m_data_reg.mean_cycles   <= mean_reg;
            m_data_reg.latest_ns     <= ns_reg[NS_LATEST];
            m_data_reg.least_ns      <= ns_reg[NS_LEAST];
            m_data_reg.most_ns       <= ns_reg[NS_MOST];
            m_data_reg.mean_ns       <= ns_reg[NS_MEAN];
            m_data_reg.measure_ok    <= present_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: rtl/csp_div.sv
// Restoring 64 by 32 bit unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module csp_div
    import csp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output      div_stat_t   stat,
    output      logic [63:0] quotient
);

    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic        ge;

    // Shift in the next dividend bit and try the subtraction.
    assign trial = {rem_reg, quo_reg[63]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '1;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[62:0], ge};
            rem_next = ge ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// File: rtl/csp_chk.sv
// Port-level checker for the profiler core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module csp_chk
    import csp_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire csp_req_t s_data,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire csp_rsp_t m_data
);

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_m_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");

    // a read keeps the block busy at least for the following cycle
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.req_type == REQ_READ |=> !s_ready)
        else $error("ready after read accepted");

    // no result appears in the cycle after an accepted transaction
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result without sequencing");

endmodule

bind critical_section_cycle_profiler_core csp_chk u_csp_chk (.*);

`default_nettype wire

// File: tb/critical_section_cycle_profiler_core_tb.sv
// Self-checking testbench for the critical section cycle profiler core.
`timescale 1ns / 1ps

module critical_section_cycle_profiler_core_tb;
    import csp_pkg::*;

    // Settling wait for a read in flight, which runs up to five 64-step divisions.
    localparam int READ_SETTLE = 400;
    localparam int HOLD_CYCLES = 3000;
    localparam logic [7:0] NEST_TOP = 8'hFF;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_index = CFG_CORE_CLOCK_HZ;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    csp_req_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    csp_rsp_t    m_data;

    always #2 aclk = ~aclk;

    critical_section_cycle_profiler_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Request transactions waiting to be offered, and statistics reads still owed.
    csp_req_t req_backlog[$];
    csp_rsp_t stats_expected[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_asked     = 0;
    int unsigned hold_taken     = 0;
    int unsigned hold_left      = 0;
    int unsigned mismatch_count = 0;
    int unsigned items_queued   = 0;
    logic [31:0] clock_now      = '0;

    // Shadow of the profiler: configuration and statistics state.
    logic [31:0] clk_hz;
    logic        cnt_present;
    logic [7:0]  nest_lvl;
    logic        sec_open;
    logic [31:0] stamp;
    logic [31:0] tally;
    logic [31:0] recent;
    logic [31:0] shortest;
    logic [31:0] longest;
    logic [63:0] total;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    task automatic clear_shadow_stats();
        nest_lvl = '0;
        sec_open = 1'b0;
        stamp    = '0;
        tally    = '0;
        recent   = '0;
        shortest = '0;
        longest  = '0;
        total    = '0;
    endtask

    // Rounded ns conversion, zero for a stopped clock, saturating at 32 bits.
    function automatic logic [31:0] cycles_to_ns(logic [31:0] c);
        logic [63:0] q;
        if (clk_hz == 32'd0) begin
            return 32'd0;
        end
        q = ({32'd0, c} * 64'd1_000_000_000 + {33'd0, clk_hz[31:1]}) / {32'd0, clk_hz};
        return (q > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    // Apply one accepted request; a read leaves a statistics record to expect.
    task automatic profile_request(csp_req_t r);
        logic [31:0] span;
        logic [63:0] quot;
        logic [31:0] mean;
        csp_rsp_t    want;
        case (r.req_type)
            REQ_ENTER: begin
                if (cnt_present) begin
                    if (nest_lvl == '0) begin
                        stamp    = r.cycle_now;
                        sec_open = 1'b1;
                    end
                    // depth sticks at the top, so that enter is lost
                    if (nest_lvl != NEST_TOP) begin
                        nest_lvl = nest_lvl + 8'd1;
                    end
                end
            end
            REQ_EXIT: begin
                if (cnt_present && nest_lvl != '0) begin
                    nest_lvl = nest_lvl - 8'd1;
                    if (nest_lvl == '0 && sec_open) begin
                        span     = r.cycle_now - stamp;  // wraps modulo 2^32
                        sec_open = 1'b0;
                        recent   = span;
                        if (total > ~64'd0 - {32'd0, span}) begin
                            total = ~64'd0;
                        end else begin
                            total = total + {32'd0, span};
                        end
                        if (tally == '0) begin
                            shortest = span;
                            longest  = span;
                        end else begin
                            if (span < shortest) shortest = span;
                            if (span > longest) longest = span;
                        end
                        if (tally != 32'hFFFF_FFFF) begin
                            tally = tally + 32'd1;
                        end
                    end
                end
            end
            REQ_CLEAR: begin
                clear_shadow_stats();
            end
            default: begin
                mean = '0;
                if (tally != '0) begin
                    quot = total / {32'd0, tally};
                    mean = (quot > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
                end
                want.samples_taken = tally;
                want.latest_cycles = recent;
                want.least_cycles  = shortest;
                want.most_cycles   = longest;
                want.cycle_sum     = total;
                want.mean_cycles   = mean;
                want.latest_ns     = cycles_to_ns(recent);
                want.least_ns      = cycles_to_ns(shortest);
                want.most_ns       = cycles_to_ns(longest);
                want.mean_ns       = cycles_to_ns(mean);
                want.measure_ok    = cnt_present;
                stats_expected.push_back(want);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: %s got %0h, expected %0h", $realtime, name, got, want);
            end
        end
    endtask

    task automatic compare_stats(csp_rsp_t got, csp_rsp_t want);
        check_field("samples_taken", 64'(got.samples_taken), 64'(want.samples_taken));
        check_field("latest_cycles", 64'(got.latest_cycles), 64'(want.latest_cycles));
        check_field("least_cycles",  64'(got.least_cycles),  64'(want.least_cycles));
        check_field("most_cycles",   64'(got.most_cycles),   64'(want.most_cycles));
        check_field("cycle_sum",     got.cycle_sum,          want.cycle_sum);
        check_field("mean_cycles",   64'(got.mean_cycles),   64'(want.mean_cycles));
        check_field("latest_ns",     64'(got.latest_ns),     64'(want.latest_ns));
        check_field("least_ns",      64'(got.least_ns),      64'(want.least_ns));
        check_field("most_ns",       64'(got.most_ns),       64'(want.most_ns));
        check_field("mean_ns",       64'(got.mean_ns),       64'(want.mean_ns));
        check_field("measure_ok",    64'(got.measure_ok),    64'(want.measure_ok));
    endtask

    // Monitor: register writes, accepted requests and accepted statistics, all
    // sampled at the rising edge. Requests are taken before results; a read
    // never completes in the cycle it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz      = '0;
            cnt_present = 1'b0;
            clear_shadow_stats();
            stats_expected.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_CORE_CLOCK_HZ) begin
                    clk_hz = cfg_wdata;
                end else begin
                    cnt_present = cfg_wdata[0];
                end
            end
            if (s_valid && s_ready) begin
                profile_request(s_data);
            end
            if (m_valid && m_ready) begin
                if (stats_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: statistics transaction with none outstanding",
                                 $realtime);
                    end
                end else begin
                    compare_stats(m_data, stats_expected.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver and receiver
    // ------------------------------------------------------------------

    // Offers the next backlog entry; payload held until the transaction is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= req_backlog.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Random back-pressure, plus a long hold-off on request so the output
    // register fills and the block has to stall its request side.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic queue_req(req_code_t kind, logic [31:0] at);
        csp_req_t r;
        r.req_type  = kind;
        r.cycle_now = at;
        req_backlog.push_back(r);
        items_queued++;
    endtask

    // Section lengths: mostly short, some medium, some full-range, a few extremes.
    function automatic logic [31:0] pick_len();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 4) return $urandom_range(1000);
        if (sel < 7) return $urandom_range(32'h000F_FFFF);
        if (sel < 9) return $urandom;
        return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'd0;
    endfunction

    // Backlog drained, nothing owed, then enough cycles for any read in flight.
    task automatic wait_quiet();
        do @(negedge aclk);
        while (req_backlog.size() != 0 || s_valid || stats_expected.size() != 0);
        repeat (READ_SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // New setting: only once the block is idle.
    task automatic set_phase(logic [31:0] hz, logic present, int unsigned idle_pct,
                             int unsigned stall_pct);
        wait_quiet();
        write_reg(CFG_CORE_CLOCK_HZ, hz);
        write_reg(CFG_COUNTER_PRESENT, {31'd0, present});
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        @(negedge aclk);
    endtask

    // One well-formed nest; inner stamps are don't-care, the outer pair sets the length.
    task automatic run_section(int unsigned depth);
        logic [31:0] t0;
        logic [31:0] span;
        t0   = clock_now;
        span = pick_len();
        queue_req(REQ_ENTER, t0);
        for (int unsigned i = 1; i < depth; i++) begin
            queue_req(REQ_ENTER, $urandom);
        end
        for (int unsigned i = 1; i < depth; i++) begin
            queue_req(REQ_EXIT, $urandom);
            if ($urandom_range(9) == 0) queue_req(REQ_READ, $urandom);
        end
        queue_req(REQ_EXIT, t0 + span);
        clock_now = t0 + span + $urandom_range(200);
    endtask

    task automatic run_random(int unsigned count);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                run_section(($urandom_range(3) == 0) ? $urandom_range(4, 2) : 1);
                if ($urandom_range(1) != 0) queue_req(REQ_READ, $urandom);
            end else if (pick < 72) begin
                queue_req(REQ_READ, $urandom);
            end else if (pick < 80) begin
                queue_req(REQ_CLEAR, $urandom);
            end else if (pick < 88) begin
                queue_req(req_code_t'($urandom_range(3)), $urandom);
            end else if (pick < 93) begin
                queue_req(REQ_EXIT, $urandom);      // stray exit
            end else if (pick < 97) begin
                queue_req(REQ_ENTER, $urandom);     // leaves a nest open until a clear
            end else begin
                clock_now = $urandom;               // counter jump, wrap coverage
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Out of reset: no counter, clock 0. Enter and exit must be ignored.
        queue_req(REQ_READ, '1);
        queue_req(REQ_ENTER, 32'd10);
        queue_req(REQ_EXIT, 32'd20);
        queue_req(REQ_READ, '0);

        set_phase(32'hFFFF_FFFF, 1'b1, 0, 0);
        queue_req(REQ_ENTER, 32'd0);           // zero-length section
        queue_req(REQ_EXIT, 32'd0);
        queue_req(REQ_READ, '1);
        queue_req(REQ_ENTER, 32'd5);           // full-range length by wrap
        queue_req(REQ_EXIT, 32'd4);
        queue_req(REQ_READ, '0);
        queue_req(REQ_ENTER, 32'd100);         // nested: outer pair counts
        queue_req(REQ_ENTER, 32'd150);
        queue_req(REQ_EXIT, 32'd200);
        queue_req(REQ_EXIT, 32'd350);
        queue_req(REQ_READ, '0);
        queue_req(REQ_EXIT, 32'd400);          // nothing open
        queue_req(REQ_CLEAR, '1);
        queue_req(REQ_READ, '0);

        // 1 Hz clock: ns values saturate.
        set_phase(32'd1, 1'b1, 0, 0);
        queue_req(REQ_ENTER, 32'hFFFF_FFF0);
        queue_req(REQ_EXIT, 32'h0000_0010);
        queue_req(REQ_READ, '0);
        queue_req(REQ_ENTER, 32'd7);           // left open across the next change

        // Counter withdrawn mid-section: the open nest must survive.
        set_phase(32'd1000, 1'b0, 0, 0);
        queue_req(REQ_EXIT, 32'd20);
        queue_req(REQ_READ, '0);
        set_phase(32'd1000, 1'b1, 0, 0);
        queue_req(REQ_EXIT, 32'd30);
        queue_req(REQ_READ, '0);

        // Random phases. The first opens with a long receiver hold-off and a
        // burst of reads so the result register fills and s_ready drops.
        set_phase(32'd100_000_000, 1'b1, 0, 0);
        hold_asked++;
        repeat (3) queue_req(REQ_READ, $urandom);
        run_random(240);

        set_phase(32'd1, 1'b1, 84, 0);
        run_random(250);

        set_phase(32'hFFFF_FFFF, 1'b1, 0, 84);
        run_random(250);

        set_phase(32'd0, 1'b1, 24, 24);
        run_random(250);

        set_phase(32'd48_000_000, 1'b0, 0, 0);
        run_random(120);

        // One nest deeper than the counter holds, then its unwinding.
        set_phase($urandom, 1'b1, 84, 0);
        queue_req(REQ_CLEAR, $urandom);
        clock_now = $urandom;
        queue_req(REQ_ENTER, clock_now);
        repeat (257) queue_req(REQ_ENTER, $urandom);
        repeat (254) queue_req(REQ_EXIT, $urandom);
        queue_req(REQ_READ, $urandom);
        queue_req(REQ_EXIT, clock_now + pick_len());
        queue_req(REQ_EXIT, $urandom);
        queue_req(REQ_READ, $urandom);
        run_random(80);

        set_phase(32'd3, 1'b1, 0, 84);
        run_random(105);

        set_phase($urandom, 1'b1, 24, 24);
        run_random(105);

        wait_quiet();
        if (mismatch_count == 0 && stats_expected.size() == 0) begin
            $display("critical_section_cycle_profiler_core: match");
        end else begin
            $display("critical_section_cycle_profiler_core: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("critical_section_cycle_profiler_core: mismatch");
        $finish;
    end

endmodule
